FILE: rtl/lwdf_pkg.sv
`timescale 1ns / 1ps
package lwdf_pkg;

  localparam int SAMPLE_W_DEF = 24;
  localparam int COEF_W_DEF   = 18;

  localparam int N_STAGE  = 5;
  localparam int N_ADAPT  = 9;
  localparam int N_ALIGN  = 4;
  localparam int N_WEIGHT = 6;

  localparam int AP_DEPTH = 558;
  localparam int BR_DEPTH = 31;
  localparam int HP_DEPTH = 392;

  // alphas in q1.24
  localparam int ALPHA_Q24 [N_ADAPT] = '{
    -3793647, 6670252, 2695713, 824650,
    -1073373, -7097903, 4339813, 1584323, 256339
  };

  // base of each stage's adaptor delay block
  localparam int AP_BASE [N_STAGE] = '{0, 18, 54, 126, 270};
  localparam int HP_BASE [N_ALIGN] = '{0, 120, 232, 328};
  localparam int HP_LEN  [N_ALIGN] = '{120, 112, 96, 64};

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_WEIGHT_HP1 = 3'd0;
  localparam cfg_idx_t REG_WEIGHT_HP2 = 3'd1;
  localparam cfg_idx_t REG_WEIGHT_HP3 = 3'd2;
  localparam cfg_idx_t REG_WEIGHT_HP4 = 3'd3;
  localparam cfg_idx_t REG_WEIGHT_HP5 = 3'd4;
  localparam cfg_idx_t REG_WEIGHT_LP5 = 3'd5;

  typedef struct packed {
    logic mul_en;
    logic crossed;
  } alu_ctl_t;

  // alpha rounded half up to q1.(cw-1)
  function automatic int alpha_q(input int j, input int cw);
    int s;
    int a;
    s = 25 - cw;
    a = ALPHA_Q24[j];
    if (s == 0) begin
      return a;
    end
    return (a + (1 <<< (s - 1))) >>> s;
  endfunction

endpackage

FILE: rtl/lwdf_ram.sv
`timescale 1ns / 1ps
module lwdf_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lwdf_alu.sv
`timescale 1ns / 1ps
module lwdf_alu
  import lwdf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
  parameter int COEF_WIDTH   = COEF_W_DEF
) (
  input  logic                           clk,
  input  alu_ctl_t                       ctl,
  input  logic signed [COEF_WIDTH-1:0]   mul_a,
  input  logic signed [SAMPLE_WIDTH:0]   mul_b,
  input  logic signed [SAMPLE_WIDTH:0]   ad_d,
  input  logic signed [SAMPLE_WIDTH-1:0] ad_a2,
  output logic signed [COEF_WIDTH+SAMPLE_WIDTH:0] prod_r,
  output logic signed [SAMPLE_WIDTH-1:0] ad_b1,
  output logic signed [SAMPLE_WIDTH-1:0] ad_b2
);

  localparam int PW = COEF_WIDTH + SAMPLE_WIDTH + 1;
  localparam int IW = SAMPLE_WIDTH + 4;
  localparam logic signed [IW-1:0] SMAX = IW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [IW-1:0] SMIN = -IW'(64'sd1 <<< (SAMPLE_WIDTH - 1));
  localparam logic signed [PW:0]   HALF = (PW+1)'(64'sd1 <<< (COEF_WIDTH - 2));

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat(input logic signed [IW-1:0] v);
    if (v > SMAX) begin
      return SAMPLE_WIDTH'(SMAX);
    end else if (v < SMIN) begin
      return SAMPLE_WIDTH'(SMIN);
    end
    return SAMPLE_WIDTH'(v);
  endfunction

  logic signed [PW:0]   p_full;
  logic signed [IW-1:0] p_w;
  logic signed [IW-1:0] t_w;
  logic signed [IW-1:0] d_w;

  // the one multiplier, registered
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= PW'(mul_a * mul_b);
    end
  end

  // adaptor outputs from the rounded product
  always_comb begin
    p_full = (PW+1)'(prod_r) + HALF;
    p_w    = IW'(p_full >>> (COEF_WIDTH - 1));
    d_w    = IW'(ad_d);
    t_w    = p_w - IW'(ad_a2);
    if (ctl.crossed) begin
      ad_b1 = sat(t_w);
      ad_b2 = sat(d_w + t_w);
    end else begin
      ad_b2 = sat(t_w);
      ad_b1 = sat(t_w - d_w);
    end
  end

endmodule

FILE: rtl/lattice_wdf_octave_filterbank_unit.sv
`timescale 1ns / 1ps
// five-octave lattice wave digital filterbank: each input word runs through five
// cascaded allpass-pair stages on one shared multiplier under a sequencer, then
// the four aligned highpass bands, the last highpass and the last lowpass are
// weighted, summed, rounded and saturated into one output word. each adaptor
// steps through delay read, subtract, multiply and writeback, each stage ends
// with a branch delay read and writeback, and each of the six weighted-sum
// terms steps through read, multiply and accumulate; the input is not ready
// while a word is worked on, but a finished word may wait at the output while
// the next word is taken. after reset a clearing pass zeroes all delay
// memories before the first word is accepted; configuration writes are taken
// at any time and are expected only while idle.
module lattice_wdf_octave_filterbank_unit
  import lwdf_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
  parameter int COEF_WIDTH   = COEF_W_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata: sample_in
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      in_tdata,
  // out_tdata: sample_out
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      out_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  cfg_idx_t                               cfg_index,
  input  logic [COEF_WIDTH-1:0]                  cfg_data
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int CW   = COEF_WIDTH;
  localparam int TW   = ((SW + 7) / 8) * 8;
  localparam int PW   = CW + SW + 1;
  localparam int ACW  = CW + SW + 4;
  localparam int AP_AW = $clog2(AP_DEPTH);
  localparam int BR_AW = $clog2(BR_DEPTH);
  localparam int HP_AW = $clog2(HP_DEPTH);
  localparam logic signed [ACW-1:0] SMAX = ACW'((64'sd1 <<< (SW - 1)) - 1);
  localparam logic signed [ACW-1:0] SMIN = -ACW'(64'sd1 <<< (SW - 1));

  function automatic logic signed [SW-1:0] sat(input logic signed [ACW-1:0] v);
    if (v > SMAX) begin
      return SW'(SMAX);
    end else if (v < SMIN) begin
      return SW'(SMIN);
    end
    return SW'(v);
  endfunction

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_AP_RD, S_AP_SUB, S_AP_MUL, S_AP_WB,
    S_BR_RD, S_BR_WB, S_MAC_RD, S_MAC_MUL, S_MAC_ACC, S_FIN
  } state_t;

  state_t state_r;

  logic [AP_AW-1:0] clr_r;
  logic [2:0]       stage_r;
  logic [3:0]       j_r;
  logic [2:0]       m_r;

  logic [4:0] ap_pos_r [N_STAGE];
  logic [3:0] br_pos_r [N_STAGE];
  logic [6:0] hp_pos_r [N_ALIGN];

  logic signed [SW-1:0]  u_r, l_r;        // upper and lower branch values
  logic signed [SW-1:0]  a2_r;
  logic signed [SW:0]    d_r;
  logic signed [SW-1:0]  hp_r [N_STAGE];
  logic signed [ACW-1:0] acc_r;
  logic signed [CW-1:0]  weight_r [N_WEIGHT];

  logic                  out_valid_r;
  logic signed [SW-1:0]  out_data_r;

  // memories
  logic [AP_AW-1:0] ap_addr;
  logic [BR_AW-1:0] br_addr;
  logic [HP_AW-1:0] hp_addr;
  logic             ap_we, br_we, hp_we;
  logic [SW-1:0]    ap_wd, br_wd, hp_wd;
  logic [SW-1:0]    ap_rd, br_rd, hp_rd;

  // shared unit
  alu_ctl_t               alu_ctl;
  logic signed [CW-1:0]   mul_a;
  logic signed [SW:0]     mul_b;
  logic signed [PW-1:0]   prod;
  logic signed [SW-1:0]   b1, b2;

  logic                   clearing;
  logic [1:0]             m_lo;
  logic signed [SW-1:0]   a1;
  logic signed [ACW-1:0]  lp_sum, hp_dif;
  logic signed [SW-1:0]   lp_w, hp_w;
  logic signed [ACW-1:0]  acc_rnd;

  assign clearing  = (state_r == S_CLEAR);
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TW'(unsigned'(out_data_r));
  assign m_lo = m_r[1:0];

  // delay addresses follow the counters; the clearing pass sweeps instead
  always_comb begin
    ap_addr = AP_AW'(AP_BASE[stage_r]) + (AP_AW'(j_r) << (stage_r + 3'd1))
              + AP_AW'(ap_pos_r[stage_r]);
    br_addr = BR_AW'((1 << stage_r) - 1) + BR_AW'(br_pos_r[stage_r]);
    hp_addr = HP_AW'(HP_BASE[m_lo]) + HP_AW'(hp_pos_r[m_lo]);
    if (clearing) begin
      ap_we = 1'b1;
      br_we = (clr_r < AP_AW'(BR_DEPTH));
      hp_we = (clr_r < AP_AW'(HP_DEPTH));
      ap_wd = '0;
      br_wd = '0;
      hp_wd = '0;
    end else begin
      ap_we = (state_r == S_AP_WB);
      br_we = (state_r == S_BR_WB);
      hp_we = (state_r == S_MAC_MUL) && (m_r < 3'(N_ALIGN));
      ap_wd = b2;
      br_wd = u_r;
      hp_wd = hp_r[m_r];
    end
  end

  lwdf_ram #(.DEPTH(AP_DEPTH), .WIDTH(SW)) u_ap_ram (
    .clk   (clk),
    .we    (ap_we),
    .waddr (clearing ? clr_r : ap_addr),
    .wdata (ap_wd),
    .raddr (ap_addr),
    .rdata (ap_rd)
  );

  lwdf_ram #(.DEPTH(BR_DEPTH), .WIDTH(SW)) u_br_ram (
    .clk   (clk),
    .we    (br_we),
    .waddr (clearing ? BR_AW'(clr_r) : br_addr),
    .wdata (br_wd),
    .raddr (br_addr),
    .rdata (br_rd)
  );

  lwdf_ram #(.DEPTH(HP_DEPTH), .WIDTH(SW)) u_hp_ram (
    .clk   (clk),
    .we    (hp_we),
    .waddr (clearing ? HP_AW'(clr_r) : hp_addr),
    .wdata (hp_wd),
    .raddr (hp_addr),
    .rdata (hp_rd)
  );

  // multiplier operands: alpha times difference, or weight times band
  always_comb begin
    alu_ctl.crossed = (j_r == 4'd0) || (j_r == 4'd4) || (j_r == 4'd5);
    alu_ctl.mul_en  = (state_r == S_AP_MUL) || (state_r == S_MAC_MUL);
    if (state_r == S_AP_MUL) begin
      mul_a = CW'(alpha_q(int'(j_r), CW));
      mul_b = d_r;
    end else begin
      mul_a = weight_r[m_r];
      if (m_r < 3'(N_ALIGN)) begin
        mul_b = (SW+1)'(signed'(hp_rd));
      end else if (m_r == 3'(N_ALIGN)) begin
        mul_b = (SW+1)'(hp_r[N_STAGE-1]);
      end else begin
        mul_b = (SW+1)'(u_r);
      end
    end
  end

  lwdf_alu #(.SAMPLE_WIDTH(SW), .COEF_WIDTH(CW)) u_alu (
    .clk    (clk),
    .ctl    (alu_ctl),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .ad_d   (d_r),
    .ad_a2  (a2_r),
    .prod_r (prod),
    .ad_b1  (b1),
    .ad_b2  (b2)
  );

  // band split and final rounding
  always_comb begin
    a1      = (j_r < 4'd4) ? u_r : l_r;
    lp_sum  = ACW'(signed'(br_rd)) + ACW'(l_r) + ACW'(1);
    hp_dif  = ACW'(l_r) - ACW'(signed'(br_rd)) + ACW'(1);
    lp_w    = sat(lp_sum >>> 1);
    hp_w    = sat(hp_dif >>> 1);
    acc_rnd = (acc_r + (ACW'(1) <<< (CW - 3))) >>> (CW - 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      stage_r     <= '0;
      j_r         <= '0;
      m_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < N_STAGE; i++) begin
        ap_pos_r[i] <= '0;
        br_pos_r[i] <= '0;
      end
      for (int i = 0; i < N_ALIGN; i++) begin
        hp_pos_r[i] <= '0;
      end
      for (int i = 0; i < N_WEIGHT; i++) begin
        weight_r[i] <= CW'(1 << (CW - 2));
      end
    end else begin
      if (cfg_valid && cfg_ready && (cfg_index <= REG_WEIGHT_LP5)) begin
        weight_r[cfg_index] <= cfg_data;
      end
      // the final state reloads the output register itself
      if (out_valid_r && out_tready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AP_AW'(1);
          if (clr_r == AP_AW'(AP_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            u_r     <= signed'(in_tdata[SW-1:0]);
            l_r     <= signed'(in_tdata[SW-1:0]);
            stage_r <= '0;
            j_r     <= '0;
            state_r <= S_AP_RD;
          end
        end
        S_AP_RD: state_r <= S_AP_SUB;
        S_AP_SUB: begin
          a2_r    <= signed'(ap_rd);
          d_r     <= (SW+1)'(signed'(ap_rd)) - (SW+1)'(a1);
          state_r <= S_AP_MUL;
        end
        S_AP_MUL: state_r <= S_AP_WB;
        S_AP_WB: begin
          if (j_r < 4'd4) begin
            u_r <= b1;
          end else begin
            l_r <= b1;
          end
          if (j_r == 4'(N_ADAPT - 1)) begin
            state_r <= S_BR_RD;
          end else begin
            j_r     <= j_r + 4'd1;
            state_r <= S_AP_RD;
          end
        end
        S_BR_RD: state_r <= S_BR_WB;
        S_BR_WB: begin
          hp_r[stage_r] <= hp_w;
          u_r <= lp_w;
          l_r <= lp_w;
          ap_pos_r[stage_r] <= (ap_pos_r[stage_r] == 5'((2 << stage_r) - 1)) ? '0
                               : ap_pos_r[stage_r] + 5'd1;
          br_pos_r[stage_r] <= (br_pos_r[stage_r] == 4'((1 << stage_r) - 1)) ? '0
                               : br_pos_r[stage_r] + 4'd1;
          j_r <= '0;
          if (stage_r == 3'(N_STAGE - 1)) begin
            m_r     <= '0;
            acc_r   <= '0;
            state_r <= S_MAC_RD;
          end else begin
            stage_r <= stage_r + 3'd1;
            state_r <= S_AP_RD;
          end
        end
        S_MAC_RD: state_r <= S_MAC_MUL;
        S_MAC_MUL: begin
          if (m_r < 3'(N_ALIGN)) begin
            hp_pos_r[m_lo] <= (hp_pos_r[m_lo] == 7'(HP_LEN[m_lo] - 1)) ? '0
                              : hp_pos_r[m_lo] + 7'd1;
          end
          state_r <= S_MAC_ACC;
        end
        S_MAC_ACC: begin
          acc_r <= acc_r + ACW'(prod);
          if (m_r == 3'(N_WEIGHT - 1)) begin
            state_r <= S_FIN;
          end else begin
            m_r     <= m_r + 3'd1;
            state_r <= S_MAC_RD;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= sat(acc_rnd);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/lwdf_chk.sv
`timescale 1ns / 1ps
module lwdf_chk #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   out_tdata
);

  // a taken word keeps the input closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after accepting a word");

  // reset starts the clearing pass with nothing to show
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("activity right after reset");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

endmodule

bind lattice_wdf_octave_filterbank_unit lwdf_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/tb_lattice_wdf_octave_filterbank_unit.sv
`timescale 1ns / 1ps
// expected band sums for the octave filterbank: own copy of delay lines, ring
// pointers and band weights, stepped once per accepted input word
class filterbank_scoreboard;
  longint allpass_mem [558];
  longint branch_mem [31];
  longint align_mem [392];
  int ap_pos [5];
  int br_pos [5];
  int hp_pos [4];
  longint band_gain [6];
  logic [23:0] expected_q [$];
  int errors;

  function new();
    for (int i = 0; i < 6; i++) band_gain[i] = 65536;
    errors = 0;
  endfunction

  function longint sat24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // round half up by s bits
  function longint round_up(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function void write_gain(lwdf_pkg::cfg_idx_t idx, logic [17:0] v);
    if (idx <= lwdf_pkg::REG_WEIGHT_LP5) band_gain[idx] = longint'($signed(v));
  endfunction

  function void note_sample(logic [23:0] s);
    longint x, u, l, a1, a2, d, p, t, b1, b2, yu, lp, acc;
    longint hp [5];
    int len, base, blen, bbase, idx;
    bit crossed, upper;
    x = longint'($signed(s));
    for (int k = 0; k < 5; k++) begin
      len = 2 << k;
      base = 9 * (len - 2);
      blen = 1 << k;
      bbase = blen - 1;
      u = x;
      l = x;
      for (int j = 0; j < 9; j++) begin
        idx = base + j * len + ap_pos[k];
        crossed = (j == 0 || j == 4 || j == 5);
        upper = (j < 4);
        a1 = upper ? u : l;
        a2 = allpass_mem[idx];
        d = a2 - a1;
        p = round_up(round_up(longint'(lwdf_pkg::ALPHA_Q24[j]), 7) * d, 17);
        t = p - a2;
        if (crossed) begin
          b1 = sat24(t);
          b2 = sat24(d + t);
        end else begin
          b2 = sat24(t);
          b1 = sat24(t - d);
        end
        allpass_mem[idx] = b2;
        if (upper) u = b1;
        else l = b1;
      end
      yu = branch_mem[bbase + br_pos[k]];
      branch_mem[bbase + br_pos[k]] = u;
      ap_pos[k] = (ap_pos[k] + 1 == len) ? 0 : ap_pos[k] + 1;
      br_pos[k] = (br_pos[k] + 1 == blen) ? 0 : br_pos[k] + 1;
      lp = sat24((yu + l + 1) >>> 1);
      hp[k] = sat24((l - yu + 1) >>> 1);
      x = lp;
    end
    acc = 0;
    for (int k = 0; k < 4; k++) begin
      idx = lwdf_pkg::HP_BASE[k] + hp_pos[k];
      acc += band_gain[k] * align_mem[idx];
      align_mem[idx] = hp[k];
      hp_pos[k] = (hp_pos[k] + 1 == lwdf_pkg::HP_LEN[k]) ? 0 : hp_pos[k] + 1;
    end
    acc += band_gain[4] * hp[4] + band_gain[5] * x;
    acc = sat24(round_up(acc, 16));
    expected_q.push_back(acc[23:0]);
  endfunction

  function void check_sample(logic [23:0] got);
    logic [23:0] want;
    if (expected_q.size() == 0) begin
      $error("sample_out: no word expected, got %0d", $signed(got));
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got !== want) begin
      $error("sample_out: expected %0d, actual %0d", $signed(want), $signed(got));
      errors++;
    end
  endfunction
endclass

module tb_lattice_wdf_octave_filterbank_unit;
  import lwdf_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;  // clearing pass + one word + stalls, several times over
  localparam int DRAIN_CYCLES   = 300;   // a little more than one word's latency

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [23:0] in_tdata;   // sample_in
  logic out_tvalid;
  logic out_tready;
  logic [23:0] out_tdata;  // sample_out
  logic cfg_valid;
  logic cfg_ready;
  cfg_idx_t cfg_index;
  logic [17:0] cfg_data;

  filterbank_scoreboard sb;
  bit idle_on;        // random gaps on both sides when set
  int quiet_cycles;

  lattice_wdf_octave_filterbank_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitors: every accepted word updates the predictor or gets checked
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_sample(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_sample(out_tdata);
  end

  // watchdog on cycles without any accepted word or configuration write
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stall before each word, none while idling is off
  initial begin
    int gap;
    out_tready = 1'b0;
    forever begin
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_sample(logic [23:0] s);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [17:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_gain(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // let the block go idle before touching the weights
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [23:0] random_sample();
    case ($urandom_range(0, 5))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return 24'($signed($urandom_range(0, 511)) - 256);
      3: return 24'($signed($urandom_range(0, 65535)) - 32768);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [17:0] gain_for(int setting);
    case (setting)
      0: return 18'h1ffff;                 // largest positive gain
      1: return 18'h20000;                 // most negative gain
      2: return 18'h0;
      3: return 18'h10000;                 // unity
      default: return 18'($urandom);
    endcase
  endfunction

  initial begin
    logic [23:0] directed [$];
    sb = new();
    idle_on = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_WEIGHT_HP1;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, impulse response, full-scale square wave
    directed = '{24'h000000, 24'h7fffff, 24'h800000, 24'hffffff, 24'h000001,
                 24'h400000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
                 24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff,
                 24'h800000, 24'h555555, 24'haaaaaa, 24'h000000, 24'h000000};
    foreach (directed[i]) send_sample(directed[i]);
    drain();

    // phases with different weight settings, extremes first
    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph % 3 != 2);
      // out-of-range register indexes must be ignored
      if (ph % 2 == 0) write_reg(cfg_idx_t'(6), 18'($urandom));
      else write_reg(cfg_idx_t'(7), 18'($urandom));
      write_reg(REG_WEIGHT_HP1, gain_for(ph));
      write_reg(REG_WEIGHT_HP2, gain_for(ph));
      write_reg(REG_WEIGHT_HP3, gain_for(ph == 2 ? 3 : ph));
      write_reg(REG_WEIGHT_HP4, gain_for(ph));
      write_reg(REG_WEIGHT_HP5, gain_for(ph));
      write_reg(REG_WEIGHT_LP5, gain_for(ph == 2 ? 0 : ph));
      for (int n = 0; n < 110; n++) begin
        if (idle_on && ph > 2) idle_on = ($urandom_range(0, 15) != 0);
        send_sample(random_sample());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
